[sv/median_of_medians_kth_largest_defines.svh]
// Assertion macros shared by the modules of the selection block.
`ifndef MEDIAN_OF_MEDIANS_KTH_LARGEST_DEFINES_SVH
`define MEDIAN_OF_MEDIANS_KTH_LARGEST_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MMKL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MMKL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/mmkl_pkg.sv]
package mmkl_pkg;

    localparam int MAX_VALUES  = 128;
    localparam int GROUP_SIZE  = 5;
    localparam int PAD_VALUE   = 9999;
    localparam int PIVOT_LIMIT = 1000;
    localparam int MED_INDEX   = 2;
    localparam int ROUND_LIMIT = 15;
    localparam int MED_DEPTH   = (MAX_VALUES + 4) / 5;

    localparam int VAL_W   = 10;
    localparam int MED_W   = 14;
    localparam int RANK_W  = 8;
    localparam int DISC_W  = 8;
    localparam int ROUND_W = 4;
    localparam int CNT_W   = $clog2(MAX_VALUES + 1);
    localparam int ADDR_W  = $clog2(MAX_VALUES);
    localparam int MADDR_W = $clog2(MED_DEPTH);
    localparam int MCNT_W  = $clog2(MED_DEPTH + 1);
    localparam int CMP_W   = ((CNT_W > RANK_W) ? CNT_W : RANK_W) + 1;

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_ROUND, S_GINIT, S_GRD, S_GSORT, S_GWR,
        S_MCRD, S_MCLT, S_MSCAN, S_MEND, S_PIV, S_PSCAN, S_DEC,
        S_CMP, S_CMPE, S_FCRD, S_FCLT, S_FSCAN, S_FEND, S_FRES, S_EMIT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_START, OP_ROUND, OP_GINIT, OP_GRD, OP_GSORT,
        OP_GWR, OP_CAND_RD, OP_CAND_LATCH, OP_SCAN, OP_MEND, OP_PIV,
        OP_DEC, OP_CMP, OP_CMPE, OP_FEND, OP_FRES, OP_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   sel_med;
    } t_dp_cmd;

    typedef struct packed {
        logic range_bad;
        logic go_round;
        logic grd_last;
        logic sort_last;
        logic gwr_last;
        logic more_groups;
        logic scan_last;
        logic cand_last;
        logic found;
        logic out_free;
        logic res_final;
    } t_dp_status;

endpackage

[sv/mmkl_if.sv]
interface mmkl_in_if import mmkl_pkg::*;;
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] value;
    logic             last_value;
    modport source (output valid, value, last_value, input ready);
    modport sink (input valid, value, last_value, output ready);
endinterface

interface mmkl_res_if import mmkl_pkg::*;;
    logic              valid;
    logic              ready;
    logic [VAL_W-1:0]  pivot;
    logic [DISC_W-1:0] discarded_count;
    logic [VAL_W-1:0]  answer;
    logic              range_error;
    logic              final_result;
    modport source (output valid, pivot, discarded_count, answer, range_error,
                    final_result, input ready);
    modport sink (input valid, pivot, discarded_count, answer, range_error,
                  final_result, output ready);
endinterface

interface mmkl_cfg_if import mmkl_pkg::*;;
    logic              valid;
    logic              ready;
    logic [RANK_W-1:0] rank_wanted;
    modport source (output valid, rank_wanted, input ready);
    modport sink (input valid, rank_wanted, output ready);
endinterface

[sv/mmkl_ram.sv]
module mmkl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/mmkl_ctrl.sv]
`include "median_of_medians_kth_largest_defines.svh"

module mmkl_ctrl import mmkl_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_last,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid && i_in_last) n_state = S_CHECK;
            S_CHECK:  n_state = i_status.range_bad ? S_EMIT : S_ROUND;
            S_ROUND:  n_state = i_status.go_round ? S_GINIT : S_FCRD;
            S_GINIT:  n_state = S_GRD;
            S_GRD:    if (i_status.grd_last) n_state = S_GSORT;
            S_GSORT:  if (i_status.sort_last) n_state = S_GWR;
            S_GWR: begin
                if (i_status.gwr_last) begin
                    n_state = i_status.more_groups ? S_GINIT : S_MCRD;
                end
            end
            S_MCRD:   n_state = S_MCLT;
            S_MCLT:   n_state = S_MSCAN;
            S_MSCAN:  if (i_status.scan_last) n_state = S_MEND;
            S_MEND:   n_state = i_status.cand_last ? S_PIV : S_MCRD;
            S_PIV:    n_state = S_PSCAN;
            S_PSCAN:  if (i_status.scan_last) n_state = S_DEC;
            S_DEC:    n_state = i_status.found ? S_EMIT : S_CMP;
            S_CMP:    if (i_status.scan_last) n_state = S_CMPE;
            S_CMPE:   n_state = S_EMIT;
            S_FCRD:   n_state = S_FCLT;
            S_FCLT:   n_state = S_FSCAN;
            S_FSCAN:  if (i_status.scan_last) n_state = S_FEND;
            S_FEND:   n_state = i_status.cand_last ? S_FRES : S_FCRD;
            S_FRES:   n_state = S_EMIT;
            S_EMIT: begin
                if (i_status.out_free) begin
                    n_state = i_status.res_final ? S_IDLE : S_ROUND;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = (r_state == S_IDLE);
        o_cmd.sel_med = 1'b0;
        o_cmd.op      = OP_NONE;
        unique case (r_state)
            S_IDLE:  o_cmd.op = i_in_valid ? OP_LOAD : OP_NONE;
            S_CHECK: o_cmd.op = OP_START;
            S_ROUND: o_cmd.op = OP_ROUND;
            S_GINIT: o_cmd.op = OP_GINIT;
            S_GRD:   o_cmd.op = OP_GRD;
            S_GSORT: o_cmd.op = OP_GSORT;
            S_GWR:   o_cmd.op = OP_GWR;
            S_MCRD: begin
                o_cmd.op      = OP_CAND_RD;
                o_cmd.sel_med = 1'b1;
            end
            S_MCLT: begin
                o_cmd.op      = OP_CAND_LATCH;
                o_cmd.sel_med = 1'b1;
            end
            S_MSCAN: begin
                o_cmd.op      = OP_SCAN;
                o_cmd.sel_med = 1'b1;
            end
            S_MEND: begin
                o_cmd.op      = OP_MEND;
                o_cmd.sel_med = 1'b1;
            end
            S_PIV:   o_cmd.op = OP_PIV;
            S_PSCAN: o_cmd.op = OP_SCAN;
            S_DEC:   o_cmd.op = OP_DEC;
            S_CMP:   o_cmd.op = OP_CMP;
            S_CMPE:  o_cmd.op = OP_CMPE;
            S_FCRD:  o_cmd.op = OP_CAND_RD;
            S_FCLT:  o_cmd.op = OP_CAND_LATCH;
            S_FSCAN: o_cmd.op = OP_SCAN;
            S_FEND:  o_cmd.op = OP_FEND;
            S_FRES:  o_cmd.op = OP_FRES;
            S_EMIT:  o_cmd.op = OP_EMIT;
            default: o_cmd.op = OP_NONE;
        endcase
    end

    `MMKL_ASSERT_NEXT(a_emit_holds, (r_state == S_EMIT) && !i_status.out_free, r_state == S_EMIT, "result lost while output busy")
    `MMKL_ASSERT_NOW(a_check_from_idle, r_state == S_CHECK, $past(r_state) == S_IDLE, "search started outside idle")
    `MMKL_ASSERT_NEXT(a_found_emits, (r_state == S_DEC) && i_status.found, r_state == S_EMIT, "found pivot not reported")

endmodule

[sv/mmkl_datapath.sv]
`include "median_of_medians_kth_largest_defines.svh"

module mmkl_datapath import mmkl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_status        o_status,
    input  logic [VAL_W-1:0]  i_value,
    input  logic              i_last_value,
    input  logic              i_cfg_valid,
    input  logic [RANK_W-1:0] i_cfg_rank,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [VAL_W-1:0]  o_pivot,
    output logic [DISC_W-1:0] o_discarded_count,
    output logic [VAL_W-1:0]  o_answer,
    output logic              o_range_error,
    output logic              o_final_result
);

    logic [CNT_W-1:0]   r_count, r_n, r_base, r_sj, r_j, r_ci, r_gt, r_eq, r_lt, r_disc;
    logic [RANK_W-1:0]  r_rank_wanted, r_rank;
    logic [ROUND_W-1:0] r_round;
    logic [2:0]         r_k, r_gsize;
    logic [VAL_W-1:0]   r_buf [GROUP_SIZE];
    logic [MCNT_W-1:0]  r_grp;
    logic [MED_W-1:0]   r_ref, r_lo, r_hi;
    logic               r_mode;
    logic [VAL_W-1:0]   r_ans;
    logic [VAL_W-1:0]   r_res_pivot, r_res_ans;
    logic [DISC_W-1:0]  r_res_disc;
    logic               r_res_err, r_res_fin;
    logic               r_out_valid;
    logic [VAL_W-1:0]   r_out_pivot, r_out_ans;
    logic [DISC_W-1:0]  r_out_disc;
    logic               r_out_err, r_out_fin;

    logic               val_we, med_we;
    logic [ADDR_W-1:0]  val_waddr, val_raddr;
    logic [VAL_W-1:0]   val_wdata, val_rdata;
    logic [MADDR_W-1:0] med_waddr, med_raddr;
    logic [MED_W-1:0]   med_wdata, med_rdata;

    logic [MED_W-1:0]   x;
    logic [CNT_W-1:0]   limit, grp_addr, count_inc, rem, half;
    logic [2:0]         k_prev;
    logic               keep, lo_hit, hi_hit;
    logic [VAL_W-1:0]   srt [GROUP_SIZE];
    logic [MED_W:0]     piv_sum;
    logic [MED_W-1:0]   piv_raw, piv;
    logic [CMP_W-1:0]   rank_x, gt_x, eq_x;

    mmkl_ram #(.WIDTH(VAL_W), .DEPTH(MAX_VALUES)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (val_waddr),
        .i_wdata (val_wdata),
        .i_raddr (val_raddr),
        .o_rdata (val_rdata)
    );

    mmkl_ram #(.WIDTH(MED_W), .DEPTH(MED_DEPTH)) u_med_ram (
        .i_clk   (i_clk),
        .i_we    (med_we),
        .i_waddr (med_waddr),
        .i_wdata (med_wdata),
        .i_raddr (med_raddr),
        .o_rdata (med_rdata)
    );

    assign x         = i_cmd.sel_med ? med_rdata : MED_W'(val_rdata);
    assign limit     = i_cmd.sel_med ? CNT_W'(r_grp) : r_n;
    assign grp_addr  = r_base + CNT_W'(r_k);
    assign k_prev    = r_k - 3'd1;
    assign count_inc = (CMP_W'(r_count) < CMP_W'(MAX_VALUES)) ? r_count + CNT_W'(1) : r_count;
    assign rem       = r_n - r_base;
    assign half      = CNT_W'(r_grp >> 1);
    assign keep      = (r_sj != '0) && (r_mode ? (x < r_ref) : (x > r_ref));
    assign rank_x    = CMP_W'(r_rank);
    assign gt_x      = CMP_W'(r_gt);
    assign eq_x      = CMP_W'(r_eq);

    // Position window of the current candidate among the sorted medians.
    assign lo_hit = (CMP_W'(r_lt) <= CMP_W'(half) - CMP_W'(1))
                 && (CMP_W'(half) - CMP_W'(1) < CMP_W'(r_lt) + eq_x);
    assign hi_hit = (CMP_W'(r_lt) <= CMP_W'(half))
                 && (CMP_W'(half) < CMP_W'(r_lt) + eq_x);

    assign piv_sum = (MED_W+1)'(r_lo) + (MED_W+1)'(r_hi);
    assign piv_raw = r_grp[0] ? r_hi : piv_sum[MED_W:1];
    assign piv     = (piv_raw > MED_W'(PIVOT_LIMIT)) ? r_lo : piv_raw;

    // One pass of odd-even transposition sort over the group buffer.
    always_comb begin
        srt = r_buf;
        if (!r_k[0]) begin
            if (r_buf[0] > r_buf[1]) begin
                srt[0] = r_buf[1];
                srt[1] = r_buf[0];
            end
            if (r_buf[2] > r_buf[3]) begin
                srt[2] = r_buf[3];
                srt[3] = r_buf[2];
            end
        end else begin
            if (r_buf[1] > r_buf[2]) begin
                srt[1] = r_buf[2];
                srt[2] = r_buf[1];
            end
            if (r_buf[3] > r_buf[4]) begin
                srt[3] = r_buf[4];
                srt[4] = r_buf[3];
            end
        end
    end

    always_comb begin
        o_status.range_bad   = (r_rank_wanted == '0) || (CMP_W'(r_rank_wanted) > CMP_W'(r_n));
        o_status.go_round    = (r_n > CNT_W'(GROUP_SIZE)) && (r_round < ROUND_W'(ROUND_LIMIT));
        o_status.grd_last    = (r_k == r_gsize);
        o_status.sort_last   = (r_k == 3'(GROUP_SIZE - 1));
        o_status.gwr_last    = (r_k == r_gsize - 3'd1);
        o_status.more_groups = ((CNT_W+1)'(r_base) + (CNT_W+1)'(GROUP_SIZE)) < (CNT_W+1)'(r_n);
        o_status.scan_last   = (r_sj == limit);
        o_status.cand_last   = (r_ci == limit - CNT_W'(1));
        o_status.found       = (rank_x > gt_x) && (rank_x <= gt_x + eq_x);
        o_status.out_free    = !r_out_valid || i_out_ready;
        o_status.res_final   = r_res_fin;
    end

    always_comb begin
        val_we    = 1'b0;
        val_waddr = r_j[ADDR_W-1:0];
        val_wdata = x[VAL_W-1:0];
        val_raddr = r_sj[ADDR_W-1:0];
        med_we    = 1'b0;
        med_waddr = r_grp[MADDR_W-1:0];
        med_wdata = (r_gsize > 3'(MED_INDEX)) ? MED_W'(r_buf[MED_INDEX]) : MED_W'(PAD_VALUE);
        med_raddr = r_sj[MADDR_W-1:0];
        unique case (i_cmd.op)
            OP_LOAD: begin
                val_we    = CMP_W'(r_count) < CMP_W'(MAX_VALUES);
                val_waddr = r_count[ADDR_W-1:0];
                val_wdata = i_value;
            end
            OP_GRD: val_raddr = grp_addr[ADDR_W-1:0];
            OP_GWR: begin
                val_we    = 1'b1;
                val_waddr = grp_addr[ADDR_W-1:0];
                val_wdata = r_buf[r_k];
                med_we    = (r_k == 3'd0);
            end
            OP_CMP: val_we = keep;
            OP_CAND_RD: begin
                val_raddr = r_ci[ADDR_W-1:0];
                med_raddr = r_ci[MADDR_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_rank_wanted <= RANK_W'(1);
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_rank_wanted <= i_cfg_rank;
            end
            if (i_cmd.op == OP_LOAD) begin
                r_count <= i_last_value ? '0 : count_inc;
            end
            if ((i_cmd.op == OP_EMIT) && o_status.out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                if (i_last_value) begin
                    r_n <= count_inc;
                end
            end
            OP_START: begin
                r_rank      <= r_rank_wanted;
                r_round     <= '0;
                r_res_pivot <= '0;
                r_res_disc  <= '0;
                r_res_ans   <= '0;
                r_res_err   <= 1'b1;
                r_res_fin   <= 1'b1;
            end
            OP_ROUND: begin
                r_base <= '0;
                r_grp  <= '0;
                r_ci   <= '0;
                r_ans  <= '0;
            end
            OP_GINIT: begin
                r_k     <= '0;
                r_gsize <= (rem > CNT_W'(GROUP_SIZE)) ? 3'(GROUP_SIZE) : rem[2:0];
                for (int i = 0; i < GROUP_SIZE; i++) begin
                    r_buf[i] <= '1;
                end
            end
            OP_GRD: begin
                if (r_k != 3'd0) begin
                    r_buf[k_prev] <= val_rdata;
                end
                r_k <= o_status.grd_last ? 3'd0 : r_k + 3'd1;
            end
            OP_GSORT: begin
                r_buf <= srt;
                r_k   <= o_status.sort_last ? 3'd0 : r_k + 3'd1;
            end
            OP_GWR: begin
                if (o_status.gwr_last) begin
                    r_k    <= 3'd0;
                    r_base <= r_base + CNT_W'(GROUP_SIZE);
                    r_grp  <= r_grp + MCNT_W'(1);
                end else begin
                    r_k <= r_k + 3'd1;
                end
            end
            OP_CAND_LATCH: begin
                r_ref <= x;
                r_sj  <= '0;
                r_gt  <= '0;
                r_eq  <= '0;
                r_lt  <= '0;
            end
            OP_SCAN: begin
                if (r_sj != '0) begin
                    if (x > r_ref) begin
                        r_gt <= r_gt + CNT_W'(1);
                    end else if (x == r_ref) begin
                        r_eq <= r_eq + CNT_W'(1);
                    end else begin
                        r_lt <= r_lt + CNT_W'(1);
                    end
                end
                r_sj <= r_sj + CNT_W'(1);
            end
            OP_MEND: begin
                if (lo_hit) begin
                    r_lo <= r_ref;
                end
                if (hi_hit) begin
                    r_hi <= r_ref;
                end
                r_ci <= r_ci + CNT_W'(1);
            end
            OP_PIV: begin
                r_ref <= piv;
                r_sj  <= '0;
                r_gt  <= '0;
                r_eq  <= '0;
                r_lt  <= '0;
            end
            OP_DEC: begin
                r_sj <= '0;
                r_j  <= '0;
                if (rank_x <= gt_x) begin
                    r_mode <= 1'b0;
                    r_disc <= r_eq + r_lt;
                end else if (o_status.found) begin
                    r_res_pivot <= r_ref[VAL_W-1:0];
                    r_res_disc  <= DISC_W'(r_gt + r_lt);
                    r_res_ans   <= r_ref[VAL_W-1:0];
                    r_res_err   <= 1'b0;
                    r_res_fin   <= 1'b1;
                end else begin
                    r_mode <= 1'b1;
                    r_disc <= r_gt + r_eq;
                    r_rank <= RANK_W'(rank_x - gt_x - eq_x);
                end
            end
            OP_CMP: begin
                if (keep) begin
                    r_j <= r_j + CNT_W'(1);
                end
                r_sj <= r_sj + CNT_W'(1);
            end
            OP_CMPE: begin
                r_n         <= r_j;
                r_round     <= r_round + ROUND_W'(1);
                r_res_pivot <= r_ref[VAL_W-1:0];
                r_res_disc  <= DISC_W'(r_disc);
                r_res_ans   <= '0;
                r_res_err   <= 1'b0;
                r_res_fin   <= 1'b0;
            end
            OP_FEND: begin
                if (o_status.found) begin
                    r_ans <= r_ref[VAL_W-1:0];
                end
                r_ci <= r_ci + CNT_W'(1);
            end
            OP_FRES: begin
                r_res_pivot <= '0;
                r_res_disc  <= '0;
                r_res_ans   <= r_ans;
                r_res_err   <= 1'b0;
                r_res_fin   <= 1'b1;
            end
            OP_EMIT: begin
                if (o_status.out_free) begin
                    r_out_pivot <= r_res_pivot;
                    r_out_disc  <= r_res_disc;
                    r_out_ans   <= r_res_ans;
                    r_out_err   <= r_res_err;
                    r_out_fin   <= r_res_fin;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid       = r_out_valid;
    assign o_pivot           = r_out_pivot;
    assign o_discarded_count = r_out_disc;
    assign o_answer          = r_out_ans;
    assign o_range_error     = r_out_err;
    assign o_final_result    = r_out_fin;

    `MMKL_ASSERT_NOW(a_count_bound, 1'b1, CMP_W'(r_count) <= CMP_W'(MAX_VALUES), "load count above capacity")
    `MMKL_ASSERT_NOW(a_compact_order, i_cmd.op == OP_CMP, r_j <= r_sj, "compaction write passed read")
    `MMKL_ASSERT_NOW(a_rank_range, i_cmd.op == OP_ROUND, (r_rank != '0) && (CMP_W'(r_rank) <= CMP_W'(r_n)), "rank left outside set")

endmodule

[sv/median_of_medians_kth_largest.sv]
// Finds the k-th largest of a loaded set of values by median-of-medians
// rounds. Values enter one item per cycle and are written to a value
// memory; the item marked last_value starts the search, during which no
// further item is taken. Each round sorts groups of five in place (a
// read pass over each group, five sort passes, a write pass), then picks
// the pivot among the group medians by counting ranks, then counts the
// set against the pivot in one pass and, unless the pivot is the answer,
// compacts it in a second. Every round reports its pivot and the number
// of values dropped. The closing step selects the answer among the
// remaining n values by rank counting. The speed of each scan is set by
// the single read port of the value memory or of the median memory that
// it goes through. Rank k is written through the configuration channel,
// which is always ready and must only be used while the block is idle.
// Results wait in an output register, so loading the next set may begin
// while the final result of the last search is still waiting to be taken.
module median_of_medians_kth_largest import mmkl_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mmkl_in_if.sink    i_in,
    mmkl_cfg_if.sink   i_cfg,
    mmkl_res_if.source o_res
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // The single register is taken on any cycle.
    assign i_cfg.ready = 1'b1;

    // Sequencer for loading, rounds, final selection and result hand-off.
    mmkl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_last  (i_in.last_value),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Memories, counters, group sorter, pivot logic and output register.
    mmkl_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_value           (i_in.value),
        .i_last_value      (i_in.last_value),
        .i_cfg_valid       (i_cfg.valid),
        .i_cfg_rank        (i_cfg.rank_wanted),
        .o_out_valid       (o_res.valid),
        .i_out_ready       (o_res.ready),
        .o_pivot           (o_res.pivot),
        .o_discarded_count (o_res.discarded_count),
        .o_answer          (o_res.answer),
        .o_range_error     (o_res.range_error),
        .o_final_result    (o_res.final_result)
    );

endmodule
